[rtl/core/stack_with_statistics_defines.svh]
// assertion macros for the stack with statistics rtl
`ifndef STACK_WITH_STATISTICS_DEFINES_SVH
`define STACK_WITH_STATISTICS_DEFINES_SVH

// condition implies consequence in the same cycle
`define SWS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("sws assertion failed");

// condition implies consequence in the following cycle
`define SWS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sws assertion failed");

`endif

[rtl/core/sws_pkg.sv]
// types and constants of the stack with statistics
package sws_pkg;

  localparam logic [2:0] KIND_PUSH   = 3'd0;
  localparam logic [2:0] KIND_POP    = 3'd1;
  localparam logic [2:0] KIND_SEARCH = 3'd2;
  localparam logic [2:0] KIND_CLEAR  = 3'd3;

  localparam logic signed [31:0] WORD_NEG_ONE = -32'sd1;
  localparam logic signed [31:0] WORD_MIN     = 32'sh8000_0000;
  localparam logic signed [31:0] WORD_MAX     = 32'sh7fff_ffff;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OP,
    S_POPSUB,
    S_START,
    S_RUN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic latch;
    logic apply;
    logic pop_sub;
    logic start;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic pop_rd;
    logic scan_busy;
    logic div_busy;
    logic out_free;
  } sts_t;

endpackage

[rtl/core/sws_if.sv]
// valid/ready channel interfaces for operation and result words
interface sws_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        kind;
  logic signed [31:0] value;
  logic signed [31:0] key;

  modport source (output valid, output kind, output value, output key, input ready);
  modport sink   (input valid, input kind, input value, input key, output ready);
endinterface

interface sws_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] top_value;
  logic [8:0]         count;
  logic               is_empty;
  logic               is_full;
  logic signed [39:0] total;
  logic signed [31:0] average;
  logic signed [31:0] largest;
  logic signed [31:0] smallest;
  logic               found;
  logic               ignored;

  modport source (output valid, output top_value, output count, output is_empty,
                  output is_full, output total, output average, output largest,
                  output smallest, output found, output ignored, input ready);
  modport sink   (input valid, input top_value, input count, input is_empty,
                  input is_full, input total, input average, input largest,
                  input smallest, input found, input ignored, output ready);
endinterface

[rtl/core/stack_with_statistics.sv]
// Bounded LIFO stack of signed words with sum, average, max, min and search per operation.
// One operation word is taken at a time; its result word waits on the walk over the
// held entries through the single read port of the entry memory, one entry a cycle,
// running alongside the serial divider for the average, one quotient bit a cycle; a pop
// adds a subtract step first and the divider stays idle on an empty stack. The result
// sits in an output register, so the next operation word is taken while it still
// waits. No clearing pass follows reset.
module stack_with_statistics #(
  parameter int DEPTH = 256
) (
  input  logic     clk,
  input  logic     rst_n,
  sws_in_if.sink   in_ch,
  sws_out_if.source out_ch
);
  import sws_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sws_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sws_dp #(.DEPTH(DEPTH)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_kind  (in_ch.kind),
    .in_value (in_ch.value),
    .in_key   (in_ch.key),
    .cmd      (cmd),
    .sts      (sts),
    .out_ch   (out_ch)
  );

endmodule

[rtl/core/sws_ctrl.sv]
// sequencing state machine of the stack with statistics
module sws_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  sws_pkg::sts_t sts,
  output sws_pkg::cmd_t cmd
);
  import sws_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_OP;
      S_OP:     state_nxt = sts.pop_rd ? S_POPSUB : S_START;
      S_POPSUB: state_nxt = S_START;
      S_START:  state_nxt = S_RUN;
      S_RUN:    if (!sts.scan_busy && !sts.div_busy) state_nxt = S_DONE;
      S_DONE:   if (sts.out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      S_OP:     cmd.apply = 1'b1;
      S_POPSUB: cmd.pop_sub = 1'b1;
      S_START:  cmd.start = 1'b1;
      S_RUN:    cmd = '0;
      S_DONE:   cmd.load = sts.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule

[rtl/core/sws_dp.sv]
// entry memory, counters, scan unit, serial divider and result register
module sws_dp #(
  parameter int DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [2:0]         in_kind,
  input  logic signed [31:0] in_value,
  input  logic signed [31:0] in_key,
  input  sws_pkg::cmd_t      cmd,
  output sws_pkg::sts_t      sts,
  sws_out_if.source          out_ch
);
  import sws_pkg::*;
  `include "stack_with_statistics_defines.svh"

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int TW = 33 + AW;
  localparam int SW = $clog2(TW + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [31:0]        mem [DEPTH];
  logic [2:0]         kind_r;
  logic signed [31:0] value_r, key_r;
  logic [CW-1:0]      count_r;
  logic signed [TW-1:0] total_r;
  logic               ignored_r;

  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic signed [31:0] rd_data_r;
  logic               rdv_r;

  logic [CW-1:0]      idx_r;
  logic               scan_on_r;
  logic signed [31:0] hi_r, lo_r, top_r;
  logic               found_r;

  logic [TW-1:0]      dvd_r;
  logic [CW-1:0]      rem_r;
  logic [SW-1:0]      step_r;
  logic               neg_r;
  logic [CW:0]        rem_sh;
  logic               q_bit;

  logic               empty, full, scan_rd;
  logic signed [31:0] quot;

  logic               out_valid_r;

  assign empty   = (count_r == '0);
  assign full    = (count_r == DEPTH_C);
  assign scan_rd = scan_on_r && (idx_r < count_r);

  assign sts.pop_rd    = (kind_r == KIND_POP) && !empty;
  assign sts.scan_busy = scan_on_r;
  assign sts.div_busy  = (step_r != '0);
  assign sts.out_free  = !out_valid_r || out_ch.ready;

  // memory ports
  assign mem_we    = cmd.apply && (kind_r == KIND_PUSH) && !full;
  assign mem_waddr = count_r[AW-1:0];
  assign mem_re    = (cmd.apply && sts.pop_rd) || scan_rd;
  assign mem_raddr = scan_rd ? idx_r[AW-1:0] : AW'(count_r - CW'(1));

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= value_r;
  end

  always_ff @(posedge clk) begin
    if (mem_re) rd_data_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_r  <= in_kind;
      value_r <= in_value;
      key_r   <= in_key;
    end
  end

  // count, running sum and refusal flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      total_r   <= '0;
      ignored_r <= 1'b0;
    end else if (cmd.apply) begin
      case (kind_r)
        KIND_PUSH: begin
          if (full) begin
            ignored_r <= 1'b1;
          end else begin
            ignored_r <= 1'b0;
            count_r <= count_r + CW'(1);
            total_r <= total_r + TW'(value_r);
          end
        end
        KIND_POP: ignored_r <= empty;
        KIND_CLEAR: begin
          ignored_r <= 1'b0;
          count_r <= '0;
          total_r <= '0;
        end
        default: ignored_r <= 1'b0;
      endcase
    end else if (cmd.pop_sub) begin
      count_r <= count_r - CW'(1);
      total_r <= total_r - TW'(rd_data_r);
    end
  end

  // scan walks entries bottom to top, the last one read is the top
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_on_r <= 1'b0;
      rdv_r     <= 1'b0;
      idx_r     <= '0;
    end else if (cmd.start) begin
      scan_on_r <= 1'b1;
      rdv_r     <= 1'b0;
      idx_r     <= '0;
    end else if (scan_on_r) begin
      rdv_r <= scan_rd;
      if (scan_rd) idx_r <= idx_r + CW'(1);
      if (!scan_rd && !rdv_r) scan_on_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      hi_r    <= WORD_MIN;
      lo_r    <= WORD_MAX;
      found_r <= 1'b0;
      top_r   <= WORD_NEG_ONE;
    end else if (rdv_r) begin
      top_r <= rd_data_r;
      if (rd_data_r > hi_r) hi_r <= rd_data_r;
      if (rd_data_r < lo_r) lo_r <= rd_data_r;
      if ((kind_r == KIND_SEARCH) && (rd_data_r == key_r)) found_r <= 1'b1;
    end
  end

  // restoring divider, one quotient bit a cycle, quotient shifts into dvd_r
  assign rem_sh = {rem_r, dvd_r[TW-1]};
  assign q_bit  = (rem_sh >= {1'b0, count_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (cmd.start) begin
      step_r <= empty ? '0 : SW'(TW);
    end else if (step_r != '0) begin
      step_r <= step_r - SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      neg_r <= total_r[TW-1];
      dvd_r <= total_r[TW-1] ? TW'(-total_r) : TW'(total_r);
      rem_r <= '0;
    end else if (step_r != '0) begin
      dvd_r <= {dvd_r[TW-2:0], q_bit};
      rem_r <= q_bit ? CW'(rem_sh - {1'b0, count_r}) : CW'(rem_sh);
    end
  end

  assign quot = neg_r ? -$signed(dvd_r[31:0]) : $signed(dvd_r[31:0]);

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_ch.top_value <= empty ? WORD_NEG_ONE : top_r;
      out_ch.count     <= 9'(count_r);
      out_ch.is_empty  <= empty;
      out_ch.is_full   <= full;
      out_ch.total     <= empty ? 40'sd0 : 40'(total_r);
      out_ch.average   <= empty ? 32'sd0 : quot;
      out_ch.largest   <= hi_r;
      out_ch.smallest  <= lo_r;
      out_ch.found     <= found_r;
      out_ch.ignored   <= ignored_r;
    end
  end

  assign out_ch.valid = out_valid_r;

  `SWS_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= DEPTH_C)
  `SWS_ASSERT_NOW(a_load_idle, clk, rst_n, cmd.load, !scan_on_r && (step_r == '0))
  `SWS_ASSERT_NXT(a_pop_dec, clk, rst_n, cmd.pop_sub, count_r == $past(count_r) - CW'(1))

endmodule
